### sv/ame_pkg.sv
package ame_pkg;

    localparam int MEM_DEPTH_DEF = 256;
    localparam int MAX_IND_DEF   = 4;

    typedef enum logic [4:0] {
        CMD_NOP    = 5'd0,
        CMD_READ   = 5'd1,
        CMD_WRITE  = 5'd2,
        CMD_END    = 5'd3,
        CMD_LOAD   = 5'd4,
        CMD_STORE  = 5'd5,
        CMD_ADD    = 5'd6,
        CMD_SUB    = 5'd7,
        CMD_MULT   = 5'd8,
        CMD_DIV    = 5'd9,
        CMD_ADDI   = 5'd10,
        CMD_SUBI   = 5'd11,
        CMD_MULTI  = 5'd12,
        CMD_DIVI   = 5'd13,
        CMD_LOADI  = 5'd14,
        CMD_BR     = 5'd15,
        CMD_BEQ    = 5'd16,
        CMD_BNE    = 5'd17,
        CMD_BGE    = 5'd18,
        CMD_BG     = 5'd19,
        CMD_BLE    = 5'd20,
        CMD_BL     = 5'd21,
        CMD_LOADAT = 5'd22,
        CMD_STOREAT = 5'd23
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CMD  = 2'd1,
        ERR_ADDR = 2'd2,
        ERR_DIV  = 2'd3
    } err_t;

    // datapath operations requested by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LATCH,
        OP_CLEAR,
        OP_MEM_RD,
        OP_MEM_WR,
        OP_MUL,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_EXEC,
        OP_HALT_HOLD
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ptr_from_mem;
        logic use_mem_val;
        logic div_by_mem;
        logic [1:0] err;
    } ctl_t;

    typedef struct packed {
        logic clear_done;
        logic addr_ok;
        logic div_zero;
        logic div_done;
        logic [4:0] cmd;
        logic [2:0] levels;
        logic halted;
    } sts_t;

endpackage

### sv/ame_datapath.sv
module ame_datapath #(
    parameter int MEM_DEPTH = 256,
    parameter int MAX_IND   = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ame_pkg::ctl_t        ctl,
    output ame_pkg::sts_t        sts,
    input  logic [4:0]           command,
    input  logic signed [31:0]   operand,
    input  logic [2:0]           indirection_levels,
    input  logic signed [31:0]   read_value,
    input  logic [15:0]          start_line,
    output logic [15:0]          next_line,
    output logic                 write_valid,
    output logic signed [31:0]   write_value,
    output logic signed [31:0]   accumulator_out,
    output logic                 halted,
    output logic [1:0]           error_code
);
    import ame_pkg::*;

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LW = $clog2(MAX_IND + 1) + 1;

    logic [31:0] mem [MEM_DEPTH];
    logic [31:0] rdata_reg;
    logic [AW:0] clr_reg;
    logic [4:0]  cmd_reg;
    logic [31:0] opnd_reg, rd_reg, ptr_reg, acc_reg, prod_reg;
    logic [2:0]  lev_reg;
    logic [15:0] line_reg;
    logic        halt_reg;
    logic [31:0] dq_reg, drem_reg, dmag_reg;
    logic        dneg_reg;
    logic [5:0]  dcnt_reg;
    logic [2:0]  lev_sat;
    logic [31:0] ptr_cur, dvsr, dmag_b;
    logic        tk;
    logic [32:0] rsub;

    always_comb
    begin
        if (indirection_levels == 3'd0)
            lev_sat = 3'd1;
        else if ({1'b0, indirection_levels} > LW'(MAX_IND))
            lev_sat = 3'(MAX_IND);
        else
            lev_sat = indirection_levels;
    end

    assign ptr_cur = ctl.ptr_from_mem ? rdata_reg : ptr_reg;
    assign dvsr    = ctl.div_by_mem ? rdata_reg : opnd_reg;
    assign dmag_b  = dvsr[31] ? (32'd0 - dvsr) : dvsr;
    assign rsub    = {drem_reg, dq_reg[31]} - {1'b0, dmag_reg};

    always_comb
    begin
        case (cmd_reg)
            CMD_BR:  tk = 1'b1;
            CMD_BEQ: tk = (acc_reg == 32'd0);
            CMD_BNE: tk = (acc_reg != 32'd0);
            CMD_BGE: tk = !acc_reg[31];
            CMD_BG:  tk = !acc_reg[31] && (acc_reg != 32'd0);
            CMD_BLE: tk = acc_reg[31] || (acc_reg == 32'd0);
            default: tk = acc_reg[31];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_CLEAR)
            mem[clr_reg[AW-1:0]] <= 32'd0;
        else if (ctl.op == OP_MEM_WR)
            mem[ptr_cur[AW-1:0]] <= acc_reg;
        if (ctl.op == OP_MEM_RD)
            rdata_reg <= mem[ptr_cur[AW-1:0]];
        if (ctl.op == OP_LATCH)
        begin
            cmd_reg  <= command;
            opnd_reg <= operand;
            rd_reg   <= read_value;
            lev_reg  <= lev_sat;
        end
        if (ctl.op == OP_MEM_RD || ctl.op == OP_LATCH)
            ptr_reg <= (ctl.op == OP_LATCH) ? operand : ptr_cur;
        if (ctl.op == OP_MUL)
            prod_reg <= acc_reg * (ctl.use_mem_val ? rdata_reg : opnd_reg);
        if (ctl.op == OP_DIV_START)
        begin
            dq_reg   <= acc_reg[31] ? (32'd0 - acc_reg) : acc_reg;
            drem_reg <= 32'd0;
            dmag_reg <= dmag_b;
            dneg_reg <= acc_reg[31] ^ dvsr[31];
            dcnt_reg <= 6'd0;
        end
        else if (ctl.op == OP_DIV_STEP)
        begin
            if (!rsub[32])
                drem_reg <= rsub[31:0];
            else
                drem_reg <= {drem_reg[30:0], dq_reg[31]};
            dq_reg   <= {dq_reg[30:0], !rsub[32]};
            dcnt_reg <= dcnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            acc_reg     <= '0;
            line_reg    <= 16'd1;
            halt_reg    <= 1'b0;
            next_line   <= 16'd1;
            write_valid <= 1'b0;
            write_value <= '0;
            error_code  <= '0;
        end
        else
        begin
            if (ctl.op == OP_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (ctl.op == OP_EXEC)
            begin
                write_valid <= 1'b0;
                write_value <= '0;
                error_code  <= ctl.err;
                if (ctl.err != ERR_NONE)
                begin
                    halt_reg  <= 1'b1;
                    next_line <= line_reg;
                end
                else
                begin
                    line_reg  <= line_reg + 16'd1;
                    next_line <= line_reg + 16'd1;
                    case (cmd_reg) inside
                        CMD_READ:
                            acc_reg <= rd_reg;
                        CMD_WRITE:
                        begin
                            write_valid <= 1'b1;
                            write_value <= acc_reg;
                        end
                        CMD_END:
                        begin
                            halt_reg  <= 1'b1;
                            line_reg  <= line_reg;
                            next_line <= line_reg;
                        end
                        CMD_LOAD, CMD_LOADAT:
                            acc_reg <= rdata_reg;
                        CMD_ADD:
                            acc_reg <= acc_reg + rdata_reg;
                        CMD_SUB:
                            acc_reg <= acc_reg - rdata_reg;
                        CMD_MULT, CMD_MULTI:
                            acc_reg <= prod_reg;
                        CMD_DIV, CMD_DIVI:
                            acc_reg <= dneg_reg ? (32'd0 - dq_reg) : dq_reg;
                        CMD_ADDI:
                            acc_reg <= acc_reg + opnd_reg;
                        CMD_SUBI:
                            acc_reg <= acc_reg - opnd_reg;
                        CMD_LOADI:
                            acc_reg <= opnd_reg;
                        [CMD_BR:CMD_BL]:
                            if (tk)
                            begin
                                line_reg  <= opnd_reg[15:0] + 16'd1 - start_line;
                                next_line <= opnd_reg[15:0] + 16'd1 - start_line;
                            end
                        default:
                            ;
                    endcase
                end
            end
            else if (ctl.op == OP_HALT_HOLD)
            begin
                write_valid <= 1'b0;
                write_value <= '0;
                error_code  <= ERR_NONE;
                next_line   <= line_reg;
            end
        end
    end

    assign accumulator_out = acc_reg;
    assign halted          = halt_reg;

    assign sts.clear_done = (clr_reg == (AW+1)'(MEM_DEPTH));
    assign sts.addr_ok    = (ptr_cur < 32'(MEM_DEPTH));
    assign sts.div_zero   = (dvsr == 32'd0);
    assign sts.div_done   = (dcnt_reg == 6'd32);
    assign sts.cmd        = cmd_reg;
    assign sts.levels     = lev_reg;
    assign sts.halted     = halt_reg;
endmodule

### sv/ame_ctrl.sv
module ame_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output ame_pkg::ctl_t  ctl,
    input  ame_pkg::sts_t  sts
);
    import ame_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DEC   = 10'b0000000100,
        S_RDW   = 10'b0000001000,
        S_RDCHK = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_EXEC  = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_WR    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       frm_reg, frm_next;
    logic [1:0] err_reg, err_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            frm_reg   <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            frm_reg   <= frm_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        frm_next         = frm_reg;
        err_next         = err_reg;
        ctl.op           = OP_IDLE;
        ctl.ptr_from_mem = frm_reg;
        ctl.use_mem_val  = (sts.cmd == CMD_MULT);
        ctl.div_by_mem   = (sts.cmd == CMD_DIV);
        ctl.err          = err_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.op = OP_CLEAR;
                if (sts.clear_done)
                begin
                    ctl.op     = OP_IDLE;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
                if (in_valid)
                begin
                    ctl.op     = OP_LATCH;
                    frm_next   = 1'b0;
                    err_next   = ERR_NONE;
                    cnt_next   = '0;
                    state_next = S_DEC;
                end
            S_DEC:
            begin
                ctl.ptr_from_mem = 1'b0;
                if (sts.halted)
                begin
                    ctl.op     = OP_HALT_HOLD;
                    state_next = S_OUT;
                end
                else
                    case (sts.cmd) inside
                        [CMD_LOAD:CMD_DIV], CMD_LOADAT, CMD_STOREAT:
                            if (!sts.addr_ok)
                            begin
                                err_next   = ERR_ADDR;
                                state_next = S_EXEC;
                            end
                            else if (sts.cmd == CMD_STORE)
                                state_next = S_WR;
                            else
                            begin
                                ctl.op     = OP_MEM_RD;
                                state_next = S_RDW;
                            end
                        CMD_MULTI:
                            state_next = S_MUL;
                        CMD_DIVI:
                            if (sts.div_zero)
                            begin
                                err_next   = ERR_DIV;
                                state_next = S_EXEC;
                            end
                            else
                            begin
                                ctl.op     = OP_DIV_START;
                                state_next = S_DIV;
                            end
                        [CMD_NOP:CMD_END], CMD_ADDI, CMD_SUBI, CMD_LOADI, [CMD_BR:CMD_BL]:
                            state_next = S_EXEC;
                        default:
                        begin
                            err_next   = ERR_CMD;
                            state_next = S_EXEC;
                        end
                    endcase
            end
            S_RDW:
            begin
                // read data now valid for the pointer held in ptr_reg
                frm_next   = 1'b1;
                state_next = S_RDCHK;
            end
            S_RDCHK:
            begin
                if (sts.cmd == CMD_LOADAT || sts.cmd == CMD_STOREAT)
                begin
                    if (cnt_reg == sts.levels)
                        state_next = S_EXEC;
                    else if (!sts.addr_ok)
                    begin
                        err_next   = ERR_ADDR;
                        state_next = S_EXEC;
                    end
                    else if (cnt_reg + 3'd1 == sts.levels && sts.cmd == CMD_STOREAT)
                    begin
                        ctl.op     = OP_MEM_RD;
                        frm_next   = 1'b0;
                        state_next = S_WR;
                    end
                    else
                    begin
                        ctl.op     = OP_MEM_RD;
                        frm_next   = 1'b0;
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = S_RDW;
                    end
                end
                else if (sts.cmd == CMD_MULT)
                    state_next = S_MUL;
                else if (sts.cmd == CMD_DIV)
                begin
                    if (sts.div_zero)
                    begin
                        err_next   = ERR_DIV;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        ctl.op     = OP_DIV_START;
                        state_next = S_DIV;
                    end
                end
                else
                    state_next = S_EXEC;
            end
            S_MUL:
            begin
                ctl.op     = OP_MUL;
                state_next = S_EXEC;
            end
            S_DIV:
                if (sts.div_done)
                    state_next = S_EXEC;
                else
                    ctl.op = OP_DIV_STEP;
            S_WR:
            begin
                ctl.ptr_from_mem = 1'b0;
                ctl.op           = OP_MEM_WR;
                state_next       = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.op     = OP_EXEC;
                state_next = S_OUT;
            end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule

### sv/accumulator_machine_execute.sv
// Executes one decoded accumulator-machine instruction per request and returns one result
// per request. The controller works on one instruction at a time: a new request is taken
// only once the result of the last one has been accepted. Memory operands and the pointer
// chains of LOAD@ and STORE@ go through the single memory read port; DIV and DIV= use a
// radix-2 divider that holds the controller until the quotient is complete. After reset a
// clearing pass zeroes the data memory, one cell per cycle, before the first instruction
// is taken; start_line writes are taken at any time.
module accumulator_machine_execute #(
    parameter int MEM_DEPTH       = ame_pkg::MEM_DEPTH_DEF,
    parameter int MAX_INDIRECTION = ame_pkg::MAX_IND_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [4:0]          command,
    input  logic signed [31:0]  operand,
    input  logic [2:0]          indirection_levels,
    input  logic signed [31:0]  read_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         next_line,
    output logic                write_valid,
    output logic signed [31:0]  write_value,
    output logic signed [31:0]  accumulator_out,
    output logic                halted,
    output logic [1:0]          error_code,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         start_line
);
    import ame_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic [15:0] start_line_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_line_reg <= '0;
        else if (cfg_valid)
            start_line_reg <= start_line;
    end

    ame_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    ame_datapath #(
        .MEM_DEPTH (MEM_DEPTH),
        .MAX_IND   (MAX_INDIRECTION)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .command            (command),
        .operand            (operand),
        .indirection_levels (indirection_levels),
        .read_value         (read_value),
        .start_line         (start_line_reg),
        .next_line          (next_line),
        .write_valid        (write_valid),
        .write_value        (write_value),
        .accumulator_out    (accumulator_out),
        .halted             (halted),
        .error_code         (error_code)
    );
endmodule

### tb/sv/ame_checker.sv
`timescale 1ns / 1ps

module ame_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [4:0]         command,
    input  logic signed [31:0] operand,
    input  logic [2:0]         indirection_levels,
    input  logic signed [31:0] read_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [15:0]        next_line,
    input  logic               write_valid,
    input  logic signed [31:0] write_value,
    input  logic signed [31:0] accumulator_out,
    input  logic               halted,
    input  logic [1:0]         error_code,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [15:0]        start_line,
    output int                 fail_count,
    output int                 outstanding
);
    import ame_pkg::*;

    typedef struct {
        logic [15:0] line;
        logic        wr_valid;
        logic [31:0] wr_value;
        logic [31:0] acc;
        logic        halt;
        err_t        err;
    } exec_result_t;

    exec_result_t expected_results[$];

    logic [31:0] acc_q;
    logic [31:0] mem_q [MEM_DEPTH_DEF];
    logic [15:0] line_q;
    logic        halt_q;
    logic [15:0] line_base_q;

    initial
    begin
        acc_q       = '0;
        line_q      = 16'd1;
        halt_q      = 1'b0;
        line_base_q = '0;
        foreach (mem_q[i]) mem_q[i] = '0;
    end

    function automatic logic addr_valid(logic [31:0] a);
        return a < MEM_DEPTH_DEF;
    endfunction

    function automatic logic [31:0] quotient_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] product_low(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    function automatic exec_result_t execute_instr(logic [4:0] c, logic [31:0] opnd,
                                                   logic [2:0] lv, logic [31:0] rd);
        exec_result_t r;
        err_t         e;
        logic [15:0]  nxt;
        logic [31:0]  v;
        int           depth;
        logic         taken;
        e       = ERR_NONE;
        nxt     = line_q + 16'd1;
        r.wr_valid = 1'b0;
        r.wr_value = '0;
        if (halt_q)
        begin
            nxt = line_q;
        end
        else
        begin
            case (c)
                CMD_NOP: ;
                CMD_READ: acc_q = rd;
                CMD_WRITE:
                begin
                    r.wr_valid = 1'b1;
                    r.wr_value = acc_q;
                end
                CMD_END:
                begin
                    halt_q = 1'b1;
                    nxt    = line_q;
                end
                CMD_LOAD, CMD_STORE, CMD_ADD, CMD_SUB, CMD_MULT, CMD_DIV:
                begin
                    if (!addr_valid(opnd))
                    begin
                        e = ERR_ADDR;
                    end
                    else
                    begin
                        v = mem_q[opnd[7:0]];
                        case (c)
                            CMD_LOAD:  acc_q = v;
                            CMD_STORE: mem_q[opnd[7:0]] = acc_q;
                            CMD_ADD:   acc_q = acc_q + v;
                            CMD_SUB:   acc_q = acc_q - v;
                            CMD_MULT:  acc_q = product_low(acc_q, v);
                            default:
                            begin
                                if (v == 0) e = ERR_DIV;
                                else acc_q = quotient_trunc(acc_q, v);
                            end
                        endcase
                    end
                end
                CMD_ADDI:  acc_q = acc_q + opnd;
                CMD_SUBI:  acc_q = acc_q - opnd;
                CMD_MULTI: acc_q = product_low(acc_q, opnd);
                CMD_DIVI:
                begin
                    if (opnd == 0) e = ERR_DIV;
                    else acc_q = quotient_trunc(acc_q, opnd);
                end
                CMD_LOADI: acc_q = opnd;
                CMD_BR, CMD_BEQ, CMD_BNE, CMD_BGE, CMD_BG, CMD_BLE, CMD_BL:
                begin
                    case (c)
                        CMD_BR:  taken = 1'b1;
                        CMD_BEQ: taken = (acc_q == 0);
                        CMD_BNE: taken = (acc_q != 0);
                        CMD_BGE: taken = !acc_q[31];
                        CMD_BG:  taken = !acc_q[31] && acc_q != 0;
                        CMD_BLE: taken = acc_q[31] || acc_q == 0;
                        default: taken = acc_q[31];
                    endcase
                    if (taken) nxt = opnd[15:0] + 16'd1 - line_base_q;
                end
                CMD_LOADAT, CMD_STOREAT:
                begin
                    depth = (lv == 0) ? 1 : (lv > MAX_IND_DEF ? MAX_IND_DEF : lv);
                    v = opnd;
                    for (int i = 0; i < depth && e == ERR_NONE; i++)
                    begin
                        if (!addr_valid(v)) e = ERR_ADDR;
                        else v = mem_q[v[7:0]];
                    end
                    if (e == ERR_NONE)
                    begin
                        if (!addr_valid(v)) e = ERR_ADDR;
                        else if (c == CMD_LOADAT) acc_q = mem_q[v[7:0]];
                        else mem_q[v[7:0]] = acc_q;
                    end
                end
                default: e = ERR_CMD;
            endcase
        end
        if (e != ERR_NONE)
        begin
            halt_q = 1'b1;
            nxt    = line_q;
        end
        line_q = nxt;
        r.line = line_q;
        r.acc  = acc_q;
        r.halt = halt_q;
        r.err  = e;
        return r;
    endfunction

    always @(posedge clk)
    begin
        exec_result_t exp_r;
        int           errs;
        errs = fail_count;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready) line_base_q = start_line;
            if (in_valid && in_ready)
                expected_results.push_back(execute_instr(command, operand,
                                                         indirection_levels, read_value));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending");
                    errs++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (next_line !== exp_r.line)
                    begin
                        $error("next_line: expected %0d actual %0d", exp_r.line, next_line);
                        errs++;
                    end
                    if (write_valid !== exp_r.wr_valid)
                    begin
                        $error("write_valid: expected %0b actual %0b",
                               exp_r.wr_valid, write_valid);
                        errs++;
                    end
                    if (write_value !== exp_r.wr_value)
                    begin
                        $error("write_value: expected %0h actual %0h",
                               exp_r.wr_value, write_value);
                        errs++;
                    end
                    if (accumulator_out !== exp_r.acc)
                    begin
                        $error("accumulator_out: expected %0h actual %0h",
                               exp_r.acc, accumulator_out);
                        errs++;
                    end
                    if (halted !== exp_r.halt)
                    begin
                        $error("halted: expected %0b actual %0b", exp_r.halt, halted);
                        errs++;
                    end
                    if (error_code !== exp_r.err)
                    begin
                        $error("error_code: expected %0d actual %0d", exp_r.err, error_code);
                        errs++;
                    end
                end
            end
        end
        fail_count  <= errs;
        outstanding <= expected_results.size();
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ame_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 160;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [4:0]         command = '0;
    logic signed [31:0] operand = '0;
    logic [2:0]         indirection_levels = '0;
    logic signed [31:0] read_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [15:0]        next_line;
    logic               write_valid;
    logic signed [31:0] write_value;
    logic signed [31:0] accumulator_out;
    logic               halted;
    logic [1:0]         error_code;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        start_line = '0;

    int fail_count;
    int outstanding;
    int sent_count = 0;
    bit idle_on = 1'b1;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    accumulator_machine_execute dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .operand(operand),
        .indirection_levels(indirection_levels), .read_value(read_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_line(next_line), .write_valid(write_valid), .write_value(write_value),
        .accumulator_out(accumulator_out), .halted(halted), .error_code(error_code),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .start_line(start_line)
    );

    ame_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .operand(operand),
        .indirection_levels(indirection_levels), .read_value(read_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_line(next_line), .write_valid(write_valid), .write_value(write_value),
        .accumulator_out(accumulator_out), .halted(halted), .error_code(error_code),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .start_line(start_line),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // result side: random stall bursts plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_done != hold_req)
        begin
            hold_done <= hold_req;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic issue(logic [4:0] c, logic [31:0] opnd, logic [2:0] lv, logic [31:0] rd);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid           <= 1'b1;
        command            <= c;
        operand            <= opnd;
        indirection_levels <= lv;
        read_value         <= rd;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic issue_op(cmd_t c, logic [31:0] opnd);
        issue(c, opnd, 3'($urandom_range(0, 7)), $urandom);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_start_line(logic [15:0] v);
        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid  <= 1'b1;
        start_line <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        return ($urandom_range(0, 1) == 0) ? 32'($signed($urandom_range(0, 40)) - 20)
                                           : $urandom;
    endfunction

    // build a pointer chain in the upper half of memory, then dereference it
    task automatic pointer_chain(cmd_t c, logic [2:0] raw_levels);
        int depth;
        int base;
        depth = (raw_levels == 0) ? 1 : (raw_levels > MAX_IND_DEF ? MAX_IND_DEF : raw_levels);
        base  = 128 + $urandom_range(0, 120);
        for (int k = 0; k < depth; k++)
        begin
            issue_op(CMD_LOADI, (k == depth - 1) ? $urandom_range(0, 127) : base + k + 1);
            issue_op(CMD_STORE, base + k);
        end
        if (c == CMD_STOREAT) issue(CMD_READ, $urandom, 3'($urandom_range(0, 7)), $urandom);
        issue(c, base, raw_levels, $urandom);
    endtask

    task automatic memory_divide();
        int t;
        logic [31:0] d;
        t = $urandom_range(0, 126);
        d = rand_word();
        if (d == 0) d = 32'd3;
        issue_op(CMD_STORE, t);
        issue_op(CMD_LOADI, d);
        issue_op(CMD_STORE, t + 1);
        issue_op(CMD_LOAD, t);
        issue_op(CMD_DIV, t + 1);
    endtask

    task automatic random_instr();
        logic [31:0] d;
        case ($urandom_range(0, 11))
            0: issue_op(CMD_NOP, $urandom);
            1: issue(CMD_READ, $urandom, 3'($urandom_range(0, 7)), rand_word());
            2: issue_op(CMD_WRITE, $urandom);
            3: issue_op(cmd_t'(CMD_LOAD + 2 * $urandom_range(0, 1) + $urandom_range(0, 1)
                               * (1 + $urandom_range(0, 1))), $urandom_range(0, 255));
            4: issue_op(CMD_STORE, $urandom_range(0, 127));
            5: issue_op(cmd_t'(CMD_ADDI + $urandom_range(0, 2)), rand_word());
            6:
            begin
                d = rand_word();
                if (d == 0) d = 32'hFFFF_FFFF;
                issue_op(CMD_DIVI, d);
            end
            7: issue_op(cmd_t'($urandom_range(CMD_BR, CMD_BL)), $urandom);
            8: memory_divide();
            9: pointer_chain(CMD_LOADAT, 3'($urandom_range(0, 7)));
            10: pointer_chain(CMD_STOREAT, 3'($urandom_range(0, 7)));
            default: issue_op(CMD_LOADI, rand_word());
        endcase
    endtask

    task automatic halting_instr();
        case ($urandom_range(0, 3))
            0: issue_op(CMD_END, $urandom);
            1: issue(5'($urandom_range(24, 31)), $urandom, 3'($urandom_range(0, 7)), $urandom);
            2: issue_op(cmd_t'($urandom_range(CMD_LOAD, CMD_DIV)),
                        ($urandom_range(0, 1) == 0) ? 32'd256 : $urandom | 32'h8000_0000);
            default: issue_op(CMD_DIVI, 32'd0);
        endcase
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_start_line(16'd0);
        issue_op(CMD_LOADI, 32'h7FFF_FFFF);
        issue_op(CMD_ADDI, 32'd1);
        issue_op(CMD_STORE, 32'd0);
        issue_op(CMD_WRITE, 32'd0);
        issue_op(CMD_DIVI, 32'hFFFF_FFFF);
        issue_op(CMD_MULTI, 32'hFFFF_FFFF);
        issue_op(CMD_SUBI, 32'h8000_0000);
        issue(CMD_READ, 32'd0, 3'd7, 32'hFFFF_FFFF);
        issue_op(CMD_STORE, 32'd255);
        issue_op(CMD_LOAD, 32'd255);
        issue_op(CMD_ADD, 32'd0);
        issue_op(CMD_SUB, 32'd255);
        issue_op(CMD_MULT, 32'd0);
        issue_op(CMD_DIV, 32'd0);
        issue_op(CMD_BR, 32'd65534);
        issue_op(CMD_NOP, 32'd0);
        for (int b = CMD_BEQ; b <= CMD_BL; b++) issue_op(cmd_t'(b), 32'(b * 3));
        issue_op(CMD_LOADI, 32'd0);
        issue_op(CMD_BEQ, 32'hFFFF_FFFF);
        pointer_chain(CMD_LOADAT, 3'd0);
        pointer_chain(CMD_STOREAT, 3'd7);

        write_start_line(16'hFFFF);
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 2) hold_req++;
            for (int n = 0; n < 110; )
            begin
                int before_cnt;
                before_cnt = sent_count;
                random_instr();
                n += sent_count - before_cnt;
            end
            write_start_line((ph == 1) ? 16'd1 : 16'($urandom));
        end

        idle_on = 1'b0;
        for (int n = 0; n < 20; n++) random_instr();
        halting_instr();
        for (int n = 0; n < 6; n++)
            issue(5'($urandom_range(0, 31)), $urandom, 3'($urandom_range(0, 7)), $urandom);
        in_valid <= 1'b0;

        wait_drained();
        repeat (60) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
